FILE: src/bts_pkg.sv
// Package for the beat tempo statistics block: types, constants and codes.
// Used by every module of the block; depends on nothing.
package bts_pkg;

	// default sizes of the tempo stores
	localparam int DEF_WINDOW_LEN    = 10;
	localparam int DEF_HISTORY_DEPTH = 256;

	// depth of the beat queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// serial divider sizes: dividend up to 66 bits, divisor up to 50 bits
	localparam int DIV_NW = 66;
	localparam int DIV_DW = 50;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	// 60 * 2^24, tempo numerator for a Q16.16 interval giving Q16.8 BPM
	localparam logic [29:0] SIXTY_Q24 = 30'd1006632960;
	localparam logic [23:0] TEMPO_MAX = 24'hFFFFFF;
	localparam logic [15:0] STAT_MAX  = 16'hFFFF;

	// register indexes
	localparam logic [1:0] CFG_HOP_SIZE    = 2'd0;
	localparam logic [1:0] CFG_SAMPLE_RATE = 2'd1;
	localparam logic [1:0] CFG_ADJUSTMENT  = 2'd2;

	localparam logic [15:0] HOP_RESET  = 16'd512;
	localparam logic [17:0] RATE_RESET = 18'd44100;

	typedef struct packed {
		logic [15:0]        hop_size;
		logic [17:0]        sample_rate;
		logic signed [15:0] adjustment;
	} bts_cfg_t;

	typedef struct packed {
		logic [31:0] frame_index;
		logic        is_beat;
	} bts_item_t;

	typedef struct packed {
		logic signed [47:0] beat_time;
		logic [23:0]        ibi_tempo;
		logic               tempo_valid;
		logic [15:0]        window_median;
		logic [15:0]        mean_tempo;
		logic [15:0]        history_median;
		logic               history_full;
	} bts_result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_TDIV,
		S_TWAIT,
		S_IDIV,
		S_IWAIT,
		S_UPD,
		S_INS_RD,
		S_INS_CMP,
		S_HRD,
		S_HWAIT,
		S_WMED,
		S_MDIV,
		S_MWAIT,
		S_OUT
	} bts_state_t;

endpackage

FILE: src/bts_chan_if.sv
// Valid/ready channel interface carrying one item of payload type T.
// Depends on nothing; payload types come from bts_pkg.
interface bts_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/bts_front.sv
// Front part: accepts frames, drops those without a beat, queues beat frames.
// Depends on bts_pkg and bts_chan_if.
module bts_front import bts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bts_chan_if.sink   items,
	bts_chan_if.source beats
);
	localparam int QA = $clog2(QUEUE_DEPTH);
	localparam int QC = $clog2(QUEUE_DEPTH + 1);

	logic [31:0]   queue_q [QUEUE_DEPTH];
	logic [QA-1:0] wr_q, rd_q;
	logic [QC-1:0] count_q;
	logic          push, pop;

	assign items.ready = (count_q != QC'(QUEUE_DEPTH));
	assign push        = items.valid && items.ready && items.data.is_beat;
	assign pop         = beats.valid && beats.ready;
	assign beats.valid = (count_q != '0);
	assign beats.data  = queue_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_q] <= items.data.frame_index;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QA'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QA'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: src/bts_div.sv
// Restoring serial divider, one quotient bit per cycle, shared by the back part.
// Depends on bts_pkg for its widths.
module bts_div import bts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] quo_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial    = {rem_q, quo_q[DIV_NW-1]};
	assign fits     = (trial >= {1'b0, den_q});
	assign done     = done_q;
	assign quotient = quo_q;

	// datapath: partial remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	// step count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CW'(1));
			if (start) begin
				cnt_q <= DIV_CW'(DIV_NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

FILE: src/bts_back.sv
// Back part: beat time, tempo, window/history stores and statistics per beat.
// Depends on bts_pkg, bts_chan_if and bts_div.
module bts_back import bts_pkg::*; #(
	parameter int WINDOW_LEN    = DEF_WINDOW_LEN,
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  bts_cfg_t   cfg,
	bts_chan_if.sink   beats,
	bts_chan_if.source results
);
	localparam int WI = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int RC = $clog2(WINDOW_LEN + 1);
	localparam int HA = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HC = $clog2(HISTORY_DEPTH + 1);

	bts_state_t state_q, state_d;

	logic [31:0]        frame_q;
	logic [47:0]        prod_q;
	logic               neg_q;
	logic signed [47:0] t_q, last_q;
	logic               seen_q;
	logic [23:0]        tempo_q;
	logic               valid_q;
	logic [23:0]        recent_q [WINDOW_LEN];
	logic [RC-1:0]      rcount_q;
	logic [WI-1:0]      rhead_q, widx_q;
	logic [47:0]        sum_q;
	logic [31:0]        icount_q;
	logic [HC-1:0]      hcount_q;
	logic [HA-1:0]      ins_q;
	logic [15:0]        wmed_q, mean_q, hmed_q;

	// sorted history memory
	logic [23:0]   hist_mem [HISTORY_DEPTH];
	logic [23:0]   rdata_q;
	logic [HA-1:0] raddr, waddr;
	logic [23:0]   wdata;
	logic          we;

	// divider
	logic              div_start, div_done;
	logic [DIV_NW-1:0] div_dividend, div_quo;
	logic [DIV_DW-1:0] div_divisor;

	// arithmetic helpers
	logic signed [49:0] pos;
	logic [48:0]        mag;
	logic [17:0]        rate;
	logic signed [48:0] d;
	logic [48:0]        sum_ext;
	logic [RC-1:0]      rank;
	logic [16:0]        hround;

	bts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign pos     = $signed({2'b00, prod_q}) - 50'(cfg.adjustment);
	assign mag     = pos[49] ? 49'(-pos) : pos[48:0];
	assign rate    = (cfg.sample_rate == '0) ? 18'd1 : cfg.sample_rate;
	assign d       = $signed({t_q[47], t_q}) - $signed({last_q[47], last_q});
	assign sum_ext = {1'b0, sum_q} + 49'(tempo_q);
	assign hround  = 17'(({1'b0, rdata_q} + 25'd128) >> 8);

	// rank of the scanned window entry, ties broken by position
	always_comb begin
		rank = '0;
		for (int j = 0; j < WINDOW_LEN; j++) begin
			if (RC'(j) < rcount_q) begin
				if ((recent_q[j] < recent_q[widx_q]) ||
				    ((WI'(j) < widx_q) && (recent_q[j] == recent_q[widx_q]))) begin
					rank = rank + 1'b1;
				end
			end
		end
	end

	// history memory port
	always_ff @(posedge clk) begin
		if (we) begin
			hist_mem[waddr] <= wdata;
		end
		rdata_q <= hist_mem[raddr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d       = state_q;
		beats.ready   = 1'b0;
		results.valid = 1'b0;
		div_start     = 1'b0;
		div_dividend  = '0;
		div_divisor   = '0;
		raddr         = '0;
		waddr         = ins_q;
		wdata         = tempo_q;
		we            = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				beats.ready = 1'b1;
				if (beats.valid) state_d = S_MUL;
			end
			S_MUL: state_d = S_TDIV;
			S_TDIV: begin
				div_start    = 1'b1;
				div_dividend = DIV_NW'({mag, 16'h0000});
				div_divisor  = DIV_DW'(rate);
				state_d      = S_TWAIT;
			end
			S_TWAIT: if (div_done) state_d = S_IDIV;
			S_IDIV: begin
				if (!seen_q) begin
					state_d = S_HRD;
				end else if (d <= 0) begin
					state_d = S_UPD;
				end else begin
					div_start    = 1'b1;
					div_dividend = DIV_NW'(SIXTY_Q24);
					div_divisor  = DIV_DW'(d[48:0]);
					state_d      = S_IWAIT;
				end
			end
			S_IWAIT: if (div_done) state_d = S_UPD;
			S_UPD: begin
				state_d = (hcount_q < HC'(HISTORY_DEPTH)) ? S_INS_RD : S_HRD;
			end
			S_INS_RD: begin
				raddr = ins_q - 1'b1;
				if (ins_q == '0) begin
					we      = 1'b1;
					state_d = S_HRD;
				end else begin
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				we = 1'b1;
				if (rdata_q >= tempo_q) begin
					wdata   = rdata_q;
					state_d = S_INS_RD;
				end else begin
					state_d = S_HRD;
				end
			end
			S_HRD: begin
				raddr   = HA'(hcount_q >> 1);
				state_d = S_HWAIT;
			end
			S_HWAIT: state_d = S_WMED;
			S_WMED: begin
				if ((rcount_q == '0) || (RC'(widx_q) == rcount_q - 1'b1)) begin
					state_d = S_MDIV;
				end
			end
			S_MDIV: begin
				if (icount_q == '0) begin
					state_d = S_OUT;
				end else begin
					div_start    = 1'b1;
					div_dividend = DIV_NW'(sum_q) + DIV_NW'({icount_q, 7'h00});
					div_divisor  = DIV_DW'({icount_q, 8'h00});
					state_d      = S_MWAIT;
				end
			end
			S_MWAIT: if (div_done) state_d = S_OUT;
			S_OUT: begin
				results.valid = 1'b1;
				if (results.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: frame_q <= beats.data;
			S_MUL: prod_q <= frame_q * cfg.hop_size;
			S_TDIV: neg_q <= pos[49];
			S_TWAIT: begin
				if (div_done) begin
					if (|div_quo[DIV_NW-1:47]) begin
						t_q <= neg_q ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
					end else begin
						t_q <= neg_q ? -$signed({1'b0, div_quo[46:0]})
						             : $signed({1'b0, div_quo[46:0]});
					end
				end
			end
			S_IDIV: begin
				valid_q <= seen_q;
				last_q  <= t_q;
				if (!seen_q || d < 0) begin
					tempo_q <= '0;
				end else if (d == 0) begin
					tempo_q <= TEMPO_MAX;
				end
			end
			S_IWAIT: begin
				if (div_done) begin
					tempo_q <= (|div_quo[DIV_NW-1:24]) ? TEMPO_MAX : div_quo[23:0];
				end
			end
			S_UPD: begin
				recent_q[rhead_q] <= tempo_q;
				ins_q             <= HA'(hcount_q);
			end
			S_INS_RD: ;
			S_INS_CMP: begin
				if (rdata_q >= tempo_q) ins_q <= ins_q - 1'b1;
			end
			S_HWAIT: begin
				hmed_q <= (hcount_q == '0) ? 16'h0000 :
				          (hround[16] ? STAT_MAX : hround[15:0]);
				widx_q <= '0;
				wmed_q <= '0;
			end
			S_WMED: begin
				if (rcount_q != '0) begin
					if (rank == (rcount_q >> 1)) wmed_q <= recent_q[widx_q][23:8];
					widx_q <= widx_q + 1'b1;
				end
			end
			S_MDIV: if (icount_q == '0) mean_q <= '0;
			S_MWAIT: begin
				if (div_done) mean_q <= (|div_quo[DIV_NW-1:16]) ? STAT_MAX : div_quo[15:0];
			end
			default: ;
		endcase
	end

	// architectural state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 1'b0;
			rcount_q <= '0;
			rhead_q  <= '0;
			sum_q    <= '0;
			icount_q <= '0;
			hcount_q <= '0;
		end else begin
			if (state_q == S_IDIV) seen_q <= 1'b1;
			if (state_q == S_UPD) begin
				rhead_q <= (rhead_q == WI'(WINDOW_LEN - 1)) ? '0 : rhead_q + 1'b1;
				if (rcount_q != RC'(WINDOW_LEN)) rcount_q <= rcount_q + 1'b1;
				sum_q <= sum_ext[48] ? '1 : sum_ext[47:0];
				if (icount_q != '1) icount_q <= icount_q + 1'b1;
			end
			if ((state_q == S_INS_RD && ins_q == '0) ||
			    (state_q == S_INS_CMP && rdata_q < tempo_q)) begin
				hcount_q <= hcount_q + 1'b1;
			end
		end
	end

	// result fields
	assign results.data.beat_time      = t_q;
	assign results.data.ibi_tempo      = tempo_q;
	assign results.data.tempo_valid    = valid_q;
	assign results.data.window_median  = wmed_q;
	assign results.data.mean_tempo     = mean_q;
	assign results.data.history_median = hmed_q;
	assign results.data.history_full   = (hcount_q == HC'(HISTORY_DEPTH));
endmodule

FILE: src/beat_tempo_statistics.sv
// Beat tempo statistics, top level: configuration registers, front and back.
// Depends on bts_pkg, bts_chan_if, bts_front and bts_back.
//
// Frames without a beat are taken whenever the queue is not full and give no
// result; beat frames go into a two-entry queue and are worked one at a time by
// the back part. The work per beat grows with the history entries shifted on
// insertion and includes any wait for the result to be taken. The first beat
// skips the tempo division and the store updates. The time is set by the one
// serial divider, 66 quotient steps per division and up to three divisions per
// beat (beat time, tempo, mean), and by the sorted history memory with one read
// port and one write port, one read and one write per shifted entry. The window
// median scan visits each window entry in turn. A result stays on the output
// until taken while the queue goes on accepting frames until it is full.
module beat_tempo_statistics import bts_pkg::*; #(
	parameter int WINDOW_LEN    = DEF_WINDOW_LEN,
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_wdata,
	bts_chan_if.sink    items,
	bts_chan_if.source  results
);
	bts_cfg_t cfg_q;

	bts_chan_if #(.T(logic [31:0])) beat_ch ();

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hop_size    <= HOP_RESET;
			cfg_q.sample_rate <= RATE_RESET;
			cfg_q.adjustment  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HOP_SIZE:    cfg_q.hop_size    <= cfg_wdata[15:0];
				CFG_SAMPLE_RATE: cfg_q.sample_rate <= cfg_wdata;
				CFG_ADJUSTMENT:  cfg_q.adjustment  <= $signed(cfg_wdata[15:0]);
				default: ;
			endcase
		end
	end

	bts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.beats  (beat_ch)
	);

	bts_back #(
		.WINDOW_LEN    (WINDOW_LEN),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.beats   (beat_ch),
		.results (results)
	);
endmodule

FILE: test/tb_beat_tempo_statistics.sv
// Testbench for beat_tempo_statistics: drives frames, predicts each beat result
// and checks it through a small scoreboard. Depends on bts_pkg, bts_chan_if and the RTL.
module tb_beat_tempo_statistics;
	import bts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          WIN_LEN    = 10;
	localparam int          HIST_DEPTH = 256;
	localparam logic [1:0]  CFG_UNUSED = 2'd3;
	localparam int          SETTLE_CYC = 800;

	// predicts beat results and holds them until the block delivers them
	class beat_scoreboard;
		bit [15:0]          hop;
		bit [17:0]          rate;
		logic signed [15:0] adj;
		longint signed      last_pos;
		bit                 seen;
		int unsigned        recent[WIN_LEN];
		int unsigned        recent_n, recent_head;
		int unsigned        hist[$];
		longint unsigned    tsum, icount;
		bts_result_t        due[$];
		int unsigned        errors, results, beats;

		function new();
			hop = HOP_RESET; rate = RATE_RESET; adj = 0;
			last_pos = 0; seen = 0; recent_n = 0; recent_head = 0;
			tsum = 0; icount = 0; errors = 0; results = 0; beats = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [17:0] val);
			case (idx)
				CFG_HOP_SIZE:    hop = val[15:0];
				CFG_SAMPLE_RATE: rate = val;
				CFG_ADJUSTMENT:  adj = val[15:0];
				default: ;
			endcase
		endfunction

		function void note_item(bts_item_t it);
			longint signed   pos, t, d;
			longint unsigned m, q, r, rd, fr, v, mean, hmed;
			int unsigned     tempo, win[$];
			int              k;
			bit              neg;
			bts_result_t     res;
			if (!it.is_beat)
				return;
			beats++;
			rd = (rate == 0) ? 1 : rate;
			fr = it.frame_index;
			pos = longint'(fr * longint'(hop)) - longint'(adj);
			neg = pos < 0;
			m = neg ? longint'(-pos) : pos;
			q = m / rd;
			r = m % rd;
			if (q >= (64'd1 << 31)) begin
				t = neg ? -(64'sd1 <<< 47) : (64'sd1 <<< 47) - 1;
			end else begin
				t = longint'((q << 16) + ((r << 16) / rd));
				if (neg) t = -t;
			end
			tempo = 0;
			res.tempo_valid = seen;
			if (seen) begin
				d = t - last_pos;
				if (d < 0) tempo = 0;
				else if (d == 0) tempo = 32'(TEMPO_MAX);
				else begin
					v = 64'd1006632960 / longint'(d);
					tempo = (v > TEMPO_MAX) ? 32'(TEMPO_MAX) : 32'(v);
				end
				recent[recent_head] = tempo;
				recent_head = (recent_head + 1) % WIN_LEN;
				if (recent_n < WIN_LEN) recent_n++;
				tsum += tempo;
				if (tsum > 64'hFFFF_FFFF_FFFF) tsum = 64'hFFFF_FFFF_FFFF;
				if (icount < 64'hFFFF_FFFF) icount++;
				// sorted insert, dropped once the store is full
				if (hist.size() < HIST_DEPTH) begin
					k = 0;
					while (k < hist.size() && hist[k] < tempo) k++;
					hist.insert(k, tempo);
				end
			end
			seen = 1;
			last_pos = t;
			mean = 0;
			hmed = 0;
			if (icount != 0) begin
				mean = (tsum + icount * 128) / (icount * 256);
				if (mean > 16'hFFFF) mean = 16'hFFFF;
			end
			if (hist.size() != 0) begin
				hmed = (longint'(hist[(hist.size() / 2) % HIST_DEPTH]) + 128) >> 8;
				if (hmed > 16'hFFFF) hmed = 16'hFFFF;
			end
			for (k = 0; k < recent_n; k++) win.insert(win.size(), recent[k]);
			win.sort();
			res.beat_time      = t[47:0];
			res.ibi_tempo      = tempo[23:0];
			res.window_median  = (recent_n == 0) ? 16'd0 : 16'(win[recent_n / 2] >> 8);
			res.mean_tempo     = mean[15:0];
			res.history_median = hmed[15:0];
			res.history_full   = hist.size() >= HIST_DEPTH;
			due.insert(due.size(), res);
		endfunction

		function void check(bts_result_t got);
			bts_result_t exp_r;
			results++;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			exp_r = due.pop_front();
			if (got.beat_time !== exp_r.beat_time || got.ibi_tempo !== exp_r.ibi_tempo ||
			    got.tempo_valid !== exp_r.tempo_valid ||
			    got.window_median !== exp_r.window_median ||
			    got.mean_tempo !== exp_r.mean_tempo ||
			    got.history_median !== exp_r.history_median ||
			    got.history_full !== exp_r.history_full) begin
				errors++;
				if (errors <= 10) begin
					$display("result %0d mismatch", results);
					$display("  exp %p", exp_r);
					$display("  got %p", got);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [17:0] cfg_wdata;
	bit          quiet;
	int unsigned cfg_count;
	longint unsigned cur_frame;

	bts_chan_if #(.T(bts_item_t))   in_if ();
	bts_chan_if #(.T(bts_result_t)) out_if ();

	beat_scoreboard sb = new();

	beat_tempo_statistics u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.items    (in_if.sink),
		.results  (out_if.source)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: check accepted items, stall now and then
	initial begin
		out_if.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_if.valid && out_if.ready)
				sb.check(out_if.data);
			out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
		end
	end

	task automatic send_item(input logic [31:0] frame, input logic beat);
		bts_item_t it;
		it.frame_index = frame;
		it.is_beat = beat;
		while (!quiet && $urandom_range(99) < 7) begin
			in_if.valid <= 0;
			@(posedge clk);
		end
		in_if.valid <= 1;
		in_if.data <= it;
		do @(posedge clk); while (!in_if.ready);
		sb.note_item(it);
	endtask

	task automatic drain();
		in_if.valid <= 0;
		@(posedge clk);
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [17:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_config(input logic [15:0] h, input logic [17:0] r, input logic [15:0] a);
		drain();
		set_reg(CFG_HOP_SIZE, h);
		set_reg(CFG_SAMPLE_RATE, r);
		set_reg(CFG_ADJUSTMENT, a);
		cfg_count++;
	endtask

	// mostly steady beat trains with random spacing, some random noise frames
	task automatic random_run(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15) begin
				send_item($urandom(), 1'($urandom_range(1)));
			end else begin
				cur_frame = (cur_frame + $urandom_range(1, ($urandom_range(9) == 0) ? 4000 : 60))
					& 64'hFFFF_FFFF;
				send_item(cur_frame[31:0], $urandom_range(99) < 40);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_wdata = 0;
		in_if.valid = 0;
		in_if.data = '0;
		quiet = 0;
		cfg_count = 1;
		cur_frame = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings, first beat, zero and negative intervals, field extremes
		send_item(32'd5, 1'b0);
		send_item(32'd0, 1'b1);
		send_item(32'd0, 1'b1);
		send_item(32'd86, 1'b1);
		send_item(32'd40, 1'b1);
		send_item(32'hFFFF_FFFF, 1'b1);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'd0, 1'b1);
		// extremes: slowest rate saturates the beat time, most negative offset
		set_config(16'hFFFF, 18'd1, 16'h8000);
		send_item(32'd0, 1'b1);
		send_item(32'd1, 1'b1);
		send_item(32'hFFFF_FFFF, 1'b1);
		send_item(32'd0, 1'b1);
		// zero rate behaves as one; unused index is ignored
		drain();
		set_reg(CFG_SAMPLE_RATE, 18'd0);
		set_reg(CFG_UNUSED, 18'h3FFFF);
		send_item(32'd0, 1'b1);
		send_item(32'd2, 1'b1);
		set_config(16'd1, 18'd192000, 16'h7FFF);
		send_item(32'd0, 1'b1);
		send_item(32'd100000, 1'b1);
		send_item(32'd100001, 1'b1);

		set_config(16'd512, 18'd44100, 16'd0);
		random_run(400);
		// hold off until the block has delivered everything
		in_if.valid <= 0;
		@(posedge clk);
		while (sb.due.size() != 0) @(posedge clk);
		quiet = 1;
		random_run(250);
		quiet = 0;
		set_config(16'd441, 18'h3FFFF, 16'hFF00);
		random_run(300);
		set_config(16'(($urandom_range(1, 65535))), 18'($urandom_range(1, 192000)),
			16'($urandom()));
		random_run(300);
		set_config(16'hFFFF, 18'd1, 16'h7FFF);
		random_run(200);
		set_config(16'd256, 18'd48000, 16'h8000);
		random_run(500);

		drain();
		$display("%0d beats over %0d register settings, %0d results checked",
			sb.beats, cfg_count, sb.results);
		if (sb.errors == 0 && sb.due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results outstanding", sb.errors, sb.due.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
